/* rtl/assert_macros.svh */
// Assertion helpers for the history ring datapath (mchr_dp).
// Each macro names the clock of the module it sits in; MCHR_ASSERT also names its reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge, skipped while reset is high.
`define MCHR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define MCHR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define MCHR_ASSERT(lbl, clk, rst, prop, msg)
`define MCHR_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* rtl/mchr_pkg.sv */
package mchr_pkg;

   // Default geometry of the history store
   localparam int CHANNEL_COUNT_DEF = 4;
   localparam int HISTORY_SIZE_DEF  = 8;

   // Field widths
   localparam int CMD_W   = 1;
   localparam int TANK_W  = 2;
   localparam int LEVEL_W = 16;
   localparam int WORD_W  = 16;
   localparam int LIMIT_W = 4;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ADD  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic load_add;   // store the accepted sample
      logic load_read;  // start a read: latch cursor, fetch the newest entry
      logic advance;    // word taken, step to the next older entry
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic read_req;   // the offered word is a read command
      logic last;       // the word on the result side ends the read
   } dp_status_type;

endpackage

/* rtl/mchr_if.sv */
interface mchr_req_if;
   logic                                valid;
   logic                                ready;
   logic [mchr_pkg::CMD_W-1:0]          command;
   logic [mchr_pkg::TANK_W-1:0]         tank;
   logic [mchr_pkg::LEVEL_W-1:0]        level;
   logic [mchr_pkg::WORD_W-1:0]         stamp_word0;
   logic [mchr_pkg::WORD_W-1:0]         stamp_word1;
   logic [mchr_pkg::WORD_W-1:0]         stamp_word2;
   logic [mchr_pkg::WORD_W-1:0]         stamp_word3;
   logic [mchr_pkg::LIMIT_W-1:0]        limit;

   modport source (
      output valid, command, tank, level, stamp_word0, stamp_word1, stamp_word2,
             stamp_word3, limit,
      input  ready
   );
   modport sink (
      input  valid, command, tank, level, stamp_word0, stamp_word1, stamp_word2,
             stamp_word3, limit,
      output ready
   );
endinterface

interface mchr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [mchr_pkg::LEVEL_W-1:0]        history_level;
   logic [mchr_pkg::WORD_W-1:0]         history_word0;
   logic [mchr_pkg::WORD_W-1:0]         history_word1;
   logic [mchr_pkg::WORD_W-1:0]         history_word2;
   logic [mchr_pkg::WORD_W-1:0]         history_word3;
   logic                                found;
   logic                                last_of_run;

   modport source (
      output valid, history_level, history_word0, history_word1, history_word2,
             history_word3, found, last_of_run,
      input  ready
   );
   modport sink (
      input  valid, history_level, history_word0, history_word1, history_word2,
             history_word3, found, last_of_run,
      output ready
   );
endinterface

/* rtl/mchr_ctrl.sv */
module mchr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  mchr_pkg::dp_status_type status,
   output mchr_pkg::ctl_cmd_type   cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SHOW = 1'b1;

   logic state_ff;
   logic state_in;
   logic req_take;
   logic rsp_take;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_SHOW);
   assign req_take  = req_valid && req_ready;
   assign rsp_take  = rsp_valid && rsp_ready;

   assign cmd.load_add  = req_take && !status.read_req;
   assign cmd.load_read = req_take && status.read_req;
   assign cmd.advance   = rsp_take && !status.last;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load_read) state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_take && status.last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/mchr_dp.sv */
`include "assert_macros.svh"

module mchr_dp #(
   parameter int CHANNEL_COUNT = mchr_pkg::CHANNEL_COUNT_DEF,
   parameter int HISTORY_SIZE  = mchr_pkg::HISTORY_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mchr_pkg::ctl_cmd_type         cmd,
   output mchr_pkg::dp_status_type       status,
   input  logic [mchr_pkg::CMD_W-1:0]    req_command,
   input  logic [mchr_pkg::TANK_W-1:0]   req_tank,
   input  logic [mchr_pkg::LEVEL_W-1:0]  req_level,
   input  logic [mchr_pkg::WORD_W-1:0]   req_stamp_word0,
   input  logic [mchr_pkg::WORD_W-1:0]   req_stamp_word1,
   input  logic [mchr_pkg::WORD_W-1:0]   req_stamp_word2,
   input  logic [mchr_pkg::WORD_W-1:0]   req_stamp_word3,
   input  logic [mchr_pkg::LIMIT_W-1:0]  req_limit,
   output logic [mchr_pkg::LEVEL_W-1:0]  rsp_history_level,
   output logic [mchr_pkg::WORD_W-1:0]   rsp_history_word0,
   output logic [mchr_pkg::WORD_W-1:0]   rsp_history_word1,
   output logic [mchr_pkg::WORD_W-1:0]   rsp_history_word2,
   output logic [mchr_pkg::WORD_W-1:0]   rsp_history_word3,
   output logic                          rsp_found,
   output logic                          rsp_last_of_run
);

   localparam int CH_W      = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
   localparam int SLOT_W    = $clog2(HISTORY_SIZE);
   localparam int CNT_W     = $clog2(HISTORY_SIZE + 1);
   localparam int MEM_DEPTH = CHANNEL_COUNT * HISTORY_SIZE;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int LEVEL_W   = mchr_pkg::LEVEL_W;
   localparam int WORD_W    = mchr_pkg::WORD_W;
   localparam int ENTRY_W   = LEVEL_W + 4 * WORD_W;
   localparam int W0_LO     = LEVEL_W;
   localparam int W1_LO     = LEVEL_W + WORD_W;
   localparam int W2_LO     = LEVEL_W + 2 * WORD_W;
   localparam int W3_LO     = LEVEL_W + 3 * WORD_W;
   localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(HISTORY_SIZE - 1);

   // Per-channel ring state
   logic [SLOT_W-1:0]  newest_ff  [CHANNEL_COUNT];
   logic               has_data_ff[CHANNEL_COUNT];
   logic               wrapped_ff [CHANNEL_COUNT];

   // Entry store: level in the low bits, then timestamp word0..word3
   logic [ENTRY_W-1:0] mem [MEM_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   // Read cursor
   logic [CH_W-1:0]    ch_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [SLOT_W-1:0]  slot_in;
   logic [CNT_W-1:0]   remain_ff;
   logic [CNT_W-1:0]   remain_in;
   logic               wrap_ff;
   logic               found_ff;

   logic [CH_W-1:0]    ch_idx;
   logic               in_range;
   logic               hit;
   logic [SLOT_W-1:0]  add_slot;
   logic               add_wrap;
   logic [CNT_W-1:0]   lim_clamped;
   logic [SLOT_W-1:0]  next_slot;
   logic               last;
   logic               wr_en;
   logic               rd_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;

   function automatic logic [ADDR_W-1:0] entry_addr(input logic [CH_W-1:0] ch,
                                                    input logic [SLOT_W-1:0] slot);
      return ADDR_W'(int'(ch) * HISTORY_SIZE + int'(slot));
   endfunction

   assign ch_idx   = CH_W'(req_tank);
   assign in_range = (int'(req_tank) < CHANNEL_COUNT);
   assign hit      = in_range && has_data_ff[ch_idx];

   assign status.read_req = (req_command == mchr_pkg::CMD_READ);
   assign status.last     = last;

   // Next slot on add: first sample goes to slot zero, wrap sets the full mark
   always_comb begin
      add_slot = '0;
      add_wrap = 1'b0;
      if (has_data_ff[ch_idx]) begin
         if (newest_ff[ch_idx] == SLOT_TOP) begin
            add_wrap = 1'b1;
         end else begin
            add_slot = newest_ff[ch_idx] + SLOT_W'(1);
         end
      end
   end

   // Clamp the limit to 1..HISTORY_SIZE
   always_comb begin
      if (req_limit == '0) begin
         lim_clamped = CNT_W'(1);
      end else if (int'(req_limit) > HISTORY_SIZE) begin
         lim_clamped = CNT_W'(HISTORY_SIZE);
      end else begin
         lim_clamped = CNT_W'(req_limit);
      end
   end

   assign next_slot = (slot_ff == '0) ? SLOT_TOP : (slot_ff - SLOT_W'(1));
   assign last      = !found_ff || (remain_ff == CNT_W'(1)) || ((slot_ff == '0) && !wrap_ff);

   assign wr_en   = cmd.load_add && in_range;
   assign wr_addr = entry_addr(ch_idx, add_slot);
   assign rd_en   = (cmd.load_read && hit) || cmd.advance;
   assign rd_addr = cmd.advance ? entry_addr(ch_ff, next_slot)
                                : entry_addr(ch_idx, newest_ff[ch_idx]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNEL_COUNT; c++) begin
            newest_ff[c]   <= SLOT_TOP;
            has_data_ff[c] <= 1'b0;
            wrapped_ff[c]  <= 1'b0;
         end
      end else if (wr_en) begin
         has_data_ff[ch_idx] <= 1'b1;
         newest_ff[ch_idx]   <= add_slot;
         if (add_wrap) wrapped_ff[ch_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {req_stamp_word3, req_stamp_word2, req_stamp_word1,
                          req_stamp_word0, req_level};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      slot_in   = slot_ff;
      remain_in = remain_ff;
      if (cmd.load_read) begin
         slot_in   = hit ? newest_ff[ch_idx] : '0;
         remain_in = lim_clamped;
      end else if (cmd.advance) begin
         slot_in   = next_slot;
         remain_in = remain_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff  <= 1'b0;
         wrap_ff   <= 1'b0;
         remain_ff <= CNT_W'(1);
         slot_ff   <= '0;
         ch_ff     <= '0;
      end else begin
         slot_ff   <= slot_in;
         remain_ff <= remain_in;
         if (cmd.load_read) begin
            found_ff <= hit;
            wrap_ff  <= hit && wrapped_ff[ch_idx];
            ch_ff    <= ch_idx;
         end
      end
   end

   assign rsp_found         = found_ff;
   assign rsp_last_of_run   = last;
   assign rsp_history_level = found_ff ? rd_data_ff[LEVEL_W-1:0]      : '0;
   assign rsp_history_word0 = found_ff ? rd_data_ff[W0_LO +: WORD_W]  : '0;
   assign rsp_history_word1 = found_ff ? rd_data_ff[W1_LO +: WORD_W]  : '0;
   assign rsp_history_word2 = found_ff ? rd_data_ff[W2_LO +: WORD_W]  : '0;
   assign rsp_history_word3 = found_ff ? rd_data_ff[W3_LO +: WORD_W]  : '0;

   `MCHR_ASSERT(a_advance_in_run, clock, reset, cmd.advance |-> (found_ff && remain_ff > CNT_W'(1)), "advance past the end of a read")
   `MCHR_ASSERT(a_no_port_clash, clock, reset, !(wr_en && rd_en), "store written and read in one cycle")
   `MCHR_ASSERT(a_empty_single, clock, reset, (cmd.load_read && !hit) |=> (last && !found_ff), "empty read not a single closing word")

endmodule

/* rtl/multi_channel_history_ring_core.sv */
// Per-channel history ring.
// req_ch carries one command word: an add stores level and a four-word
// timestamp in the next slot of channel tank; a read returns that channel's
// entries newest first on rsp_ch, at most limit of them (0 counts as 1,
// anything above the depth as the depth). A read that reaches slot 0 of a
// ring that has not wrapped yet stops there. A read of an empty or absent
// channel returns one word with found low and all data zero.
// Flow: an add is taken and produces nothing; the next word can be accepted
// in the following cycle. A read first fetches the newest entry from the
// store into a register, then offers one result per cycle while rsp_ch.ready
// is high, k results in all (k from 1 to HISTORY_SIZE); the single store
// read port, fed one address per result, sets this pace.
// req_ch.ready is high only while no read is in progress.
// When rsp_ch.ready is low the current result word holds and the walk
// through the ring pauses. last_of_run marks the final word of each read.
// Reset (synchronous, active high) empties every channel; stored entries
// are not cleared and no clearing pass runs, so the block is ready at once.
module multi_channel_history_ring_core #(
   parameter int CHANNEL_COUNT = mchr_pkg::CHANNEL_COUNT_DEF,
   parameter int HISTORY_SIZE  = mchr_pkg::HISTORY_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mchr_req_if.sink    req_ch,
   mchr_rsp_if.source  rsp_ch
);

   // Command and status between the sequencer and the ring datapath
   mchr_pkg::ctl_cmd_type   cmd;
   mchr_pkg::dp_status_type status;

   // Sequencer: take words while idle, hold each result until taken
   mchr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: ring pointers, entry store and read cursor
   mchr_dp #(
      .CHANNEL_COUNT (CHANNEL_COUNT),
      .HISTORY_SIZE  (HISTORY_SIZE)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_command       (req_ch.command),
      .req_tank          (req_ch.tank),
      .req_level         (req_ch.level),
      .req_stamp_word0   (req_ch.stamp_word0),
      .req_stamp_word1   (req_ch.stamp_word1),
      .req_stamp_word2   (req_ch.stamp_word2),
      .req_stamp_word3   (req_ch.stamp_word3),
      .req_limit         (req_ch.limit),
      .rsp_history_level (rsp_ch.history_level),
      .rsp_history_word0 (rsp_ch.history_word0),
      .rsp_history_word1 (rsp_ch.history_word1),
      .rsp_history_word2 (rsp_ch.history_word2),
      .rsp_history_word3 (rsp_ch.history_word3),
      .rsp_found         (rsp_ch.found),
      .rsp_last_of_run   (rsp_ch.last_of_run)
   );

endmodule
